### rtl/udp_port_payload_extractor_top_defines.svh
// assertion macros for the udp port payload extractor
`ifndef UDP_PORT_PAYLOAD_EXTRACTOR_TOP_DEFINES_SVH
`define UDP_PORT_PAYLOAD_EXTRACTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define UPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("udp payload extractor check failed");

// next-cycle implication, disabled during reset
`define UPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("udp payload extractor check failed");

`endif

### rtl/upe_pkg.sv
// shared constants and types for the udp port payload extractor
package upe_pkg;

  localparam logic [15:0] ETH_VLAN   = 16'h8100;
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IP_VER4    = 4'd4;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       cut;
    logic       last;
    logic [7:0] data;
  } q_word_t;

  typedef struct packed {
    logic    valid;
    q_word_t word;
  } q_push_t;

endpackage

### rtl/upe_front.sv
// frame parser: tracks header fields per byte and classifies payload words
module upe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  input  logic              in_end,
  output upe_pkg::q_push_t  push
);

  logic [15:0] dest_port_r;
  logic [15:0] byte_position_r, byte_position_nxt;
  logic        vlan_seen_r, vlan_seen_nxt;
  logic [15:0] ether_kind_r, ether_kind_nxt;
  logic [3:0]  ip_words_r, ip_words_nxt;
  logic        still_candidate_r, still_candidate_nxt;
  logic [15:0] seen_port_r, seen_port_nxt;
  logic [15:0] payload_left_r, payload_left_nxt;

  logic [15:0] pos, ek, sp, pl, base, udp;
  logic [15:0] ek_full, sp_full, pl_full, pl_dec;
  logic        vlan, cand;
  logic [3:0]  ihl;
  logic        emit, last, cut;

  always_comb begin
    pos  = in_start ? 16'd0 : byte_position_r;
    vlan = in_start ? 1'b0 : vlan_seen_r;
    ek   = in_start ? 16'd0 : ether_kind_r;
    ihl  = in_start ? 4'd0 : ip_words_r;
    cand = in_start ? 1'b1 : still_candidate_r;
    sp   = in_start ? 16'd0 : seen_port_r;
    pl   = in_start ? 16'd0 : payload_left_r;

    base    = vlan ? 16'd18 : 16'd14;
    udp     = base + {10'd0, ihl, 2'b00};
    ek_full = ek | {8'd0, in_byte};
    sp_full = sp | {8'd0, in_byte};
    pl_full = pl | {8'd0, in_byte};
    pl_dec  = pl - 16'd1;

    vlan_seen_nxt       = vlan;
    ether_kind_nxt      = ek;
    ip_words_nxt        = ihl;
    still_candidate_nxt = cand;
    seen_port_nxt       = sp;
    payload_left_nxt    = pl;
    emit = 1'b0;
    last = 1'b0;
    cut  = 1'b0;

    if (cand) begin
      if (pos == 16'd12 || (vlan && pos == 16'd16)) begin
        ether_kind_nxt = {in_byte, 8'd0};
      end else if (pos == 16'd13 || (vlan && pos == 16'd17)) begin
        ether_kind_nxt = ek_full;
        if (pos == 16'd13 && ek_full == upe_pkg::ETH_VLAN) begin
          vlan_seen_nxt = 1'b1;
        end else if (ek_full != upe_pkg::ETH_IPV4) begin
          still_candidate_nxt = 1'b0;
        end
      end else if (pos == base) begin
        ip_words_nxt = in_byte[3:0];
        if (in_byte[7:4] != upe_pkg::IP_VER4 || in_byte[3:0] < upe_pkg::IHL_MIN) begin
          still_candidate_nxt = 1'b0;
        end
      end else if (pos == base + 16'd9) begin
        if (in_byte != upe_pkg::PROTO_UDP) begin
          still_candidate_nxt = 1'b0;
        end
      end else if (pos > base) begin
        if (pos == udp + 16'd2) begin
          seen_port_nxt = {in_byte, 8'd0};
        end else if (pos == udp + 16'd3) begin
          seen_port_nxt = sp_full;
          if (sp_full != dest_port_r) begin
            still_candidate_nxt = 1'b0;
          end
        end else if (pos == udp + 16'd4) begin
          payload_left_nxt = {in_byte, 8'd0};
        end else if (pos == udp + 16'd5) begin
          if (pl_full <= upe_pkg::UDP_HDR_LEN) begin
            payload_left_nxt    = 16'd0;
            still_candidate_nxt = 1'b0;
          end else begin
            payload_left_nxt = pl_full - upe_pkg::UDP_HDR_LEN;
          end
        end else if (pos >= udp + 16'd8 && pl != 16'd0) begin
          payload_left_nxt = pl_dec;
          last = (pl_dec == 16'd0) || in_end;
          cut  = in_end && (pl_dec != 16'd0);
          emit = 1'b1;
          if (last) begin
            still_candidate_nxt = 1'b0;
          end
        end
      end
    end

    if (in_end) begin
      still_candidate_nxt = 1'b0;
    end
    byte_position_nxt = (pos == 16'hFFFF) ? pos : pos + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_port_r       <= 16'd0;
      byte_position_r   <= 16'd0;
      vlan_seen_r       <= 1'b0;
      ether_kind_r      <= 16'd0;
      ip_words_r        <= 4'd0;
      still_candidate_r <= 1'b0;
      seen_port_r       <= 16'd0;
      payload_left_r    <= 16'd0;
    end else begin
      if (cfg_wr_en) begin
        dest_port_r <= cfg_wr_data;
      end
      if (in_accept) begin
        byte_position_r   <= byte_position_nxt;
        vlan_seen_r       <= vlan_seen_nxt;
        ether_kind_r      <= ether_kind_nxt;
        ip_words_r        <= ip_words_nxt;
        still_candidate_r <= still_candidate_nxt;
        seen_port_r       <= seen_port_nxt;
        payload_left_r    <= payload_left_nxt;
      end
    end
  end

  always_comb begin
    push.valid     = in_accept && emit;
    push.word.data = in_byte;
    push.word.last = last;
    push.word.cut  = cut;
  end

endmodule

### rtl/upe_queue.sv
// small word queue between the parser and the output channel
module upe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  upe_pkg::q_push_t  push,
  input  logic              pop,
  output logic              not_full,
  output logic              not_empty,
  output upe_pkg::q_word_t  head
);

  upe_pkg::q_word_t mem_r [upe_pkg::QUEUE_DEPTH];
  logic [upe_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [upe_pkg::QCNT_W-1:0] count_r;
  logic do_push, do_pop;

  function automatic logic [upe_pkg::QPTR_W-1:0] ptr_inc(
    input logic [upe_pkg::QPTR_W-1:0] p
  );
    ptr_inc = (p == upe_pkg::QPTR_W'(upe_pkg::QUEUE_DEPTH - 1)) ?
              '0 : p + upe_pkg::QPTR_W'(1);
  endfunction

  assign not_full  = count_r != upe_pkg::QCNT_W'(upe_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push.valid && not_full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + upe_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - upe_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/udp_port_payload_extractor_top.sv
// top level of the udp port payload extractor
// Ethernet frame bytes enter one word per clock while in_tready is high; frames
// carrying one optional VLAN tag, IPv4 and UDP to the port held in the dest_port
// register give their UDP payload bytes on the output, the final one with tlast and, if
// the frame ended early, tuser set. The parser handles each byte in the cycle it is
// accepted, so the sustained rate is one word per clock while the output drains;
// payload words pass a four-word queue; in_tready falls only when that queue is full.
module udp_port_payload_extractor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // dest_port
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // data_byte
  input  logic        in_tlast,      // frame_end
  input  logic        in_tuser,      // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // payload_byte
  output logic        out_tlast,     // payload_last
  output logic        out_tuser      // payload_cut
);

  upe_pkg::q_push_t push;
  upe_pkg::q_word_t head;
  logic             in_accept;

  assign in_accept = in_tvalid && in_tready;

  upe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .in_byte     (in_tdata),
    .in_start    (in_tuser),
    .in_end      (in_tlast),
    .push        (push)
  );

  upe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tready),
    .not_full  (in_tready),
    .not_empty (out_tvalid),
    .head      (head)
  );

  assign out_tdata = head.data;
  assign out_tlast = head.last;
  assign out_tuser = head.cut;

endmodule

### rtl/upe_checker.sv
// port-level checks for the udp port payload extractor, bound to the top level
`include "udp_port_payload_extractor_top_defines.svh"

module upe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  `UPE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
  `UPE_ASSERT_SAME(a_cut_is_last, out_tvalid && out_tuser, out_tlast)
  `UPE_ASSERT_SAME(a_word_from_input, rst_n && $past(rst_n) && $rose(out_tvalid), $past(in_tvalid && in_tready))
  `UPE_ASSERT_SAME(a_ready_when_drained, !out_tvalid, in_tready)

endmodule

bind udp_port_payload_extractor_top upe_checker u_upe_checker (.*);
